// ===== hdl/lpt_pkg.sv =====
// Shared types and constants for the line point tracer.
// No dependencies; used by lpt_front, lpt_back and line_point_tracer.
package lpt_pkg;

   localparam int unsigned COORD_W = 6;
   localparam int unsigned DIM_W   = 7;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [DIM_W-1:0]   dim_type;

   // register indexes on the csr port
   typedef enum logic [0:0] {
      REG_MAP_WIDTH  = 1'b0,
      REG_MAP_HEIGHT = 1'b1
   } reg_index_type;

   localparam dim_type DIM_RESET = 7'd64;

   // one classified request, as passed from front to back
   typedef struct packed {
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by;
      coord_type dx;
      coord_type dy;
      logic      sx;     // 1: x steps up toward a
      logic      sy;     // 1: y steps up toward a
      logic      empty;  // rejected request
   } job_type;

endpackage

// ===== hdl/lpt_front.sv =====
// Front end of the line point tracer: accepts requests, classifies them and
// holds them in a two-entry queue. Depends on lpt_pkg.
module lpt_front #(
   parameter int unsigned MAP_SPAN = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lpt_pkg::coord_type req_start_x,
   input  lpt_pkg::coord_type req_start_y,
   input  lpt_pkg::coord_type req_end_x,
   input  lpt_pkg::coord_type req_end_y,
   input  lpt_pkg::dim_type  map_width,
   input  lpt_pkg::dim_type  map_height,
   output logic             job_valid,
   output lpt_pkg::job_type job,
   input  logic             job_pop
);

   localparam lpt_pkg::dim_type SPAN = lpt_pkg::dim_type'(MAP_SPAN);

   lpt_pkg::job_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   lpt_pkg::job_type new_job;
   logic             a_on_map;
   logic             push;

   always_comb begin
      a_on_map = ({1'b0, req_start_x} < map_width) && ({1'b0, req_start_x} < SPAN) &&
                 ({1'b0, req_start_y} < map_height) && ({1'b0, req_start_y} < SPAN);
      new_job.ax    = req_start_x;
      new_job.ay    = req_start_y;
      new_job.bx    = req_end_x;
      new_job.by    = req_end_y;
      new_job.dx    = (req_start_x > req_end_x) ? req_start_x - req_end_x
                                                : req_end_x - req_start_x;
      new_job.dy    = (req_start_y > req_end_y) ? req_start_y - req_end_y
                                                : req_end_y - req_start_y;
      new_job.sx    = req_end_x < req_start_x;
      new_job.sy    = req_end_y < req_start_y;
      new_job.empty = !a_on_map ||
                      ((req_start_x == req_end_x) && (req_start_y == req_end_y));
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign job_valid = (count_ff != 2'd0);
   assign job       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = job_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(job_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

// ===== hdl/lpt_back.sv =====
// Back end of the line point tracer: one Bresenham point per cycle unless rsp
// stalls; drives the registered result channel. Depends on lpt_pkg.
module lpt_back #(
   parameter int unsigned MAP_SPAN = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  lpt_pkg::job_type   job,
   output logic               job_pop,
   input  lpt_pkg::dim_type   map_width,
   input  lpt_pkg::dim_type   map_height,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lpt_pkg::coord_type rsp_point_x,
   output lpt_pkg::coord_type rsp_point_y,
   output logic               rsp_last_point,
   output logic               rsp_empty_line
);

   localparam lpt_pkg::dim_type SPAN = lpt_pkg::dim_type'(MAP_SPAN);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type          state_ff, state_in;
   lpt_pkg::job_type   job_ff, job_in;
   lpt_pkg::coord_type cur_x_ff, cur_x_in;
   lpt_pkg::coord_type cur_y_ff, cur_y_in;
   logic signed [8:0]  err_ff, err_in;
   logic               seen_ff, seen_in;
   logic               rsp_valid_ff, rsp_valid_in;
   lpt_pkg::coord_type rsp_x_ff, rsp_x_in;
   lpt_pkg::coord_type rsp_y_ff, rsp_y_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_empty_ff, rsp_empty_in;

   logic               out_free;
   logic               at_end;
   logic               cur_on_map;
   logic signed [9:0]  e2;
   logic               step_x;
   logic               step_y;
   logic signed [8:0]  dx_s;
   logic signed [8:0]  dy_s;

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      at_end     = (cur_x_ff == job_ff.ax) && (cur_y_ff == job_ff.ay);
      cur_on_map = ({1'b0, cur_x_ff} < map_width) && ({1'b0, cur_x_ff} < SPAN) &&
                   ({1'b0, cur_y_ff} < map_height) && ({1'b0, cur_y_ff} < SPAN);
      dx_s       = $signed({3'b000, job_ff.dx});
      dy_s       = $signed({3'b000, job_ff.dy});
      e2         = {err_ff, 1'b0};
      step_x     = e2 > -$signed({4'b0000, job_ff.dy});
      step_y     = e2 < $signed({4'b0000, job_ff.dx});

      state_in     = state_ff;
      job_in       = job_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      err_in       = err_ff;
      seen_in      = seen_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      job_pop      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid && out_free) begin
               job_pop = 1'b1;
               if (job.empty) begin
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = '0;
                  rsp_y_in     = '0;
                  rsp_last_in  = 1'b1;
                  rsp_empty_in = 1'b1;
               end else begin
                  job_in   = job;
                  cur_x_in = job.bx;
                  cur_y_in = job.by;
                  err_in   = $signed({3'b000, job.dx}) - $signed({3'b000, job.dy});
                  seen_in  = 1'b0;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (out_free) begin
               if (at_end) begin
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = job_ff.ax;
                  rsp_y_in     = job_ff.ay;
                  rsp_last_in  = 1'b1;
                  rsp_empty_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  // drop leading points that are off the map
                  if (seen_ff || cur_on_map) begin
                     rsp_valid_in = 1'b1;
                     rsp_x_in     = cur_x_ff;
                     rsp_y_in     = cur_y_ff;
                     rsp_last_in  = 1'b0;
                     rsp_empty_in = 1'b0;
                     seen_in      = 1'b1;
                  end
                  err_in = err_ff - (step_x ? dy_s : 9'sd0) + (step_y ? dx_s : 9'sd0);
                  if (step_x) begin
                     cur_x_in = job_ff.sx ? cur_x_ff + 6'd1 : cur_x_ff - 6'd1;
                  end
                  if (step_y) begin
                     cur_y_in = job_ff.sy ? cur_y_ff + 6'd1 : cur_y_ff - 6'd1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff       <= job_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      err_ff       <= err_in;
      seen_ff      <= seen_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_point_x    = rsp_x_ff;
   assign rsp_point_y    = rsp_y_ff;
   assign rsp_last_point = rsp_last_ff;
   assign rsp_empty_line = rsp_empty_ff;

endmodule

// ===== hdl/line_point_tracer.sv =====
// Top level of the line point tracer: map registers, front and back ends.
// Depends on lpt_pkg, lpt_front and lpt_back.
// A request (req_*) carries point a (start) and point b (end). The block
// walks a Bresenham line from b toward a and sends one response (rsp_*)
// per point, the last being a with rsp_last_point set. Leading points
// outside the map rectangle are dropped until the first point inside it.
// If a is off the map or a equals b, one response with rsp_empty_line set
// and point (0,0) is sent instead.
// Both channels handshake on valid high and stall low at a clock edge.
// The walker loads each queued request in ST_IDLE, then in ST_RUN visits
// one line point per cycle unless rsp stalls, dropped points included; a
// rejected request is answered from ST_IDLE. A two-entry queue takes new
// requests while a line is traced.
// csr_write_enable writes csr_write_data to map width (index 0) or map
// height (index 1); write only while the block is idle.
// Reset (synchronous, active high) empties the queue, stops the walker,
// drops any pending response and sets both map dimensions to 64.
// A stall on rsp holds the response register and the walker; the queue
// then fills and req_stall rises.
module line_point_tracer #(
   parameter int unsigned MAP_SPAN = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  lpt_pkg::dim_type   csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  lpt_pkg::coord_type req_start_x,
   input  lpt_pkg::coord_type req_start_y,
   input  lpt_pkg::coord_type req_end_x,
   input  lpt_pkg::coord_type req_end_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lpt_pkg::coord_type rsp_point_x,
   output lpt_pkg::coord_type rsp_point_y,
   output logic               rsp_last_point,
   output logic               rsp_empty_line
);

   lpt_pkg::dim_type map_width_ff, map_width_in;
   lpt_pkg::dim_type map_height_ff, map_height_in;

   logic             job_valid;
   lpt_pkg::job_type job;
   logic             job_pop;

   // map registers: take the write, otherwise hold
   always_comb begin
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      if (csr_write_enable) begin
         if (csr_index == lpt_pkg::REG_MAP_WIDTH) begin
            map_width_in = csr_write_data;
         end else begin
            map_height_in = csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= lpt_pkg::DIM_RESET;
         map_height_ff <= lpt_pkg::DIM_RESET;
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
      end
   end

   // classify requests and queue them
   lpt_front #(
      .MAP_SPAN (MAP_SPAN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .map_width   (map_width_ff),
      .map_height  (map_height_ff),
      .job_valid   (job_valid),
      .job         (job),
      .job_pop     (job_pop)
   );

   // walk each line and emit its points
   lpt_back #(
      .MAP_SPAN (MAP_SPAN)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (job_valid),
      .job            (job),
      .job_pop        (job_pop),
      .map_width      (map_width_ff),
      .map_height     (map_height_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_last_point (rsp_last_point),
      .rsp_empty_line (rsp_empty_line)
   );

endmodule
